// ----- rtl/core/els_pkg.sv -----
package els_pkg;

  localparam int TICK_W = 32;
  localparam int LAT_W = 31;
  localparam int CNT_W = 11;
  localparam int SUM_W = 41;
  localparam int IDX_W = 10;
  localparam int STAT_W = 3;
  localparam int DIV_STEPS = SUM_W;
  localparam int STEP_W = $clog2(DIV_STEPS + 1);

  localparam logic [CNT_W-1:0] SERIES_RESET = 11'd10;

  typedef logic [STAT_W-1:0] status_t;

  localparam status_t ST_FALLING = 3'd0;
  localparam status_t ST_STORED = 3'd1;
  localparam status_t ST_ACCEPTED = 3'd2;
  localparam status_t ST_NEGATIVE = 3'd3;
  localparam status_t ST_START_FULL = 3'd4;
  localparam status_t ST_NO_START = 3'd5;
  localparam status_t ST_RETURN_FULL = 3'd6;

endpackage

// ----- rtl/core/els_start_mem.sv -----
module els_start_mem #(
  parameter int DEPTH = 1024,
  parameter int ADDR_W = 10
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [els_pkg::TICK_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic [els_pkg::TICK_W-1:0] rd_data
);
  import els_pkg::*;

  logic [TICK_W-1:0] mem [DEPTH];
  logic [TICK_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/els_div.sv -----
module els_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [els_pkg::SUM_W-1:0] dividend,
  input  logic [els_pkg::CNT_W-1:0] divisor,
  output logic                      done,
  output logic [els_pkg::LAT_W-1:0] quotient
);
  import els_pkg::*;

  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  dvs_r;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;

  always_comb begin
    trial = {rem_r, quo_r[SUM_W-1]};
    diff = trial - {1'b0, dvs_r};
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = STEP_W'(DIV_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[CNT_W-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[CNT_W-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done = done_r;
  assign quotient = quo_r[LAT_W-1:0];

endmodule

// ----- rtl/core/edge_latency_statistics_unit.sv -----
// Path: a falling, stored or dropped edge goes from acceptance straight to the output stage;
// a rejected negative latency first passes the check state, and an accepted latency passes
// the check state and then the 41-step divider. Flow: one beat at a time; an item holds the
// input until its result is registered, and an output stall holds it longer.
// Reset: synchronous, active low; counters and statistics clear to zero, the series
// length returns to 10, and stored start ticks stay undefined until written.
module edge_latency_statistics_unit #(
  parameter int MAX_PAIRS = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [els_pkg::CNT_W-1:0]  cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_action,
  input  logic                       in_level,
  input  logic [els_pkg::TICK_W-1:0] in_tick,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [els_pkg::STAT_W-1:0] out_status,
  output logic [els_pkg::IDX_W-1:0]  out_pair_index,
  output logic [els_pkg::LAT_W-1:0]  out_latency,
  output logic [els_pkg::CNT_W-1:0]  out_accepted_count,
  output logic [els_pkg::LAT_W-1:0]  out_min_latency,
  output logic [els_pkg::LAT_W-1:0]  out_max_latency,
  output logic [els_pkg::LAT_W-1:0]  out_mean_latency
);
  import els_pkg::*;

  localparam int CAP = (MAX_PAIRS < 2047) ? MAX_PAIRS : 2047;
  localparam int ADDR_W = (CAP > 1) ? $clog2(CAP) : 1;
  localparam logic [CNT_W-1:0] CAP_L = CNT_W'(CAP);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CHK  = 4'b0010,
    S_DIV  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]  series_r;
  logic [CNT_W-1:0]  starts_r, starts_nxt;
  logic [CNT_W-1:0]  returns_r, returns_nxt;
  logic [CNT_W-1:0]  good_r, good_nxt;
  logic [LAT_W-1:0]  least_r, least_nxt;
  logic [LAT_W-1:0]  most_r, most_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [LAT_W-1:0]  mean_r, mean_nxt;
  logic [TICK_W-1:0] tick_r;
  status_t           stat_r, stat_nxt;
  logic [IDX_W-1:0]  pidx_r, pidx_nxt;
  logic [LAT_W-1:0]  lat_r, lat_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           o_stat_r;
  logic [IDX_W-1:0]  o_pidx_r;
  logic [LAT_W-1:0]  o_lat_r;
  logic [CNT_W-1:0]  o_good_r;
  logic [LAT_W-1:0]  o_least_r;
  logic [LAT_W-1:0]  o_most_r;
  logic [LAT_W-1:0]  o_mean_r;

  logic [CNT_W-1:0]  lim;
  logic              accept;
  logic              wr_en;
  logic              rd_en;
  logic [TICK_W-1:0] rd_data;
  logic [TICK_W-1:0] diff;
  logic [LAT_W-1:0]  quotient;
  logic              div_start;
  logic              div_done;
  logic              load_out;

  assign lim = (series_r > CAP_L) ? CAP_L : series_r;
  assign in_ready = (state_r == S_IDLE);
  assign accept = in_valid && in_ready;
  assign diff = tick_r - rd_data;
  assign load_out = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    starts_nxt = starts_r;
    returns_nxt = returns_r;
    good_nxt = good_r;
    least_nxt = least_r;
    most_nxt = most_r;
    sum_nxt = sum_r;
    mean_nxt = mean_r;
    stat_nxt = stat_r;
    pidx_nxt = pidx_r;
    lat_nxt = lat_r;
    wr_en = 1'b0;
    rd_en = 1'b0;
    div_start = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          pidx_nxt = '0;
          lat_nxt = '0;
          state_nxt = S_EMIT;
          if (!in_level) begin
            stat_nxt = ST_FALLING;
          end else if (!in_action) begin
            if (starts_r >= lim) begin
              stat_nxt = ST_START_FULL;
            end else begin
              wr_en = 1'b1;
              pidx_nxt = starts_r[IDX_W-1:0];
              starts_nxt = starts_r + 1'b1;
              stat_nxt = ST_STORED;
            end
          end else if (returns_r >= lim) begin
            stat_nxt = ST_RETURN_FULL;
          end else if (returns_r >= starts_r) begin
            stat_nxt = ST_NO_START;
            pidx_nxt = returns_r[IDX_W-1:0];
          end else begin
            rd_en = 1'b1;
            pidx_nxt = returns_r[IDX_W-1:0];
            returns_nxt = returns_r + 1'b1;
            state_nxt = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (diff[TICK_W-1]) begin
          stat_nxt = ST_NEGATIVE;
          state_nxt = S_EMIT;
        end else begin
          stat_nxt = ST_ACCEPTED;
          lat_nxt = diff[LAT_W-1:0];
          if (good_r == '0) begin
            least_nxt = diff[LAT_W-1:0];
            most_nxt = diff[LAT_W-1:0];
          end else begin
            if (diff[LAT_W-1:0] > most_r) begin
              most_nxt = diff[LAT_W-1:0];
            end
            if (diff[LAT_W-1:0] < least_r) begin
              least_nxt = diff[LAT_W-1:0];
            end
          end
          good_nxt = good_r + 1'b1;
          sum_nxt = sum_r + SUM_W'(diff[LAT_W-1:0]);
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          mean_nxt = quotient;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      series_r <= SERIES_RESET;
      starts_r <= '0;
      returns_r <= '0;
      good_r <= '0;
      least_r <= '0;
      most_r <= '0;
      sum_r <= '0;
      mean_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        series_r <= cfg_wdata;
      end
      starts_r <= starts_nxt;
      returns_r <= returns_nxt;
      good_r <= good_nxt;
      least_r <= least_nxt;
      most_r <= most_nxt;
      sum_r <= sum_nxt;
      mean_r <= mean_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stat_r <= stat_nxt;
    pidx_r <= pidx_nxt;
    lat_r <= lat_nxt;
    if (accept) begin
      tick_r <= in_tick;
    end
    if (load_out) begin
      o_stat_r <= stat_r;
      o_pidx_r <= pidx_r;
      o_lat_r <= lat_r;
      o_good_r <= good_r;
      o_least_r <= least_r;
      o_most_r <= most_r;
      o_mean_r <= mean_r;
    end
  end

  els_start_mem #(
    .DEPTH  (CAP),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (starts_r[ADDR_W-1:0]),
    .wr_data (in_tick),
    .rd_en   (rd_en),
    .rd_addr (returns_r[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  els_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt),
    .divisor  (good_nxt),
    .done     (div_done),
    .quotient (quotient)
  );

  assign out_valid = out_valid_r;
  assign out_status = o_stat_r;
  assign out_pair_index = o_pidx_r;
  assign out_latency = o_lat_r;
  assign out_accepted_count = o_good_r;
  assign out_min_latency = o_least_r;
  assign out_max_latency = o_most_r;
  assign out_mean_latency = o_mean_r;

endmodule

// ----- rtl/core/els_checker.sv -----
module els_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [els_pkg::STAT_W-1:0] out_status,
  input logic [els_pkg::LAT_W-1:0]  out_latency,
  input logic [els_pkg::CNT_W-1:0]  out_accepted_count,
  input logic [els_pkg::LAT_W-1:0]  out_min_latency,
  input logic [els_pkg::LAT_W-1:0]  out_max_latency,
  input logic [els_pkg::LAT_W-1:0]  out_mean_latency
);
  import els_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_latency))
    else $error("result beat changed while stalled");

  a_lat_only_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_ACCEPTED) |-> out_latency == '0)
    else $error("latency reported for a beat that was not accepted");

  a_empty_stats: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_accepted_count == '0) |->
      (out_min_latency == '0) && (out_max_latency == '0) && (out_mean_latency == '0))
    else $error("statistics nonzero with no accepted latency");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_min_latency <= out_max_latency)
    else $error("minimum latency above maximum");

  a_accepted_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_ACCEPTED) |->
      (out_accepted_count != '0) && (out_latency >= out_min_latency) &&
      (out_latency <= out_max_latency))
    else $error("accepted latency outside the reported range");

endmodule

bind edge_latency_statistics_unit els_checker u_els_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_status         (out_status),
  .out_latency        (out_latency),
  .out_accepted_count (out_accepted_count),
  .out_min_latency    (out_min_latency),
  .out_max_latency    (out_max_latency),
  .out_mean_latency   (out_mean_latency)
);
